[rtl/bbpw_pkg.sv]
// Shared widths, limits and codes for the bitmap byte to pixel write block.
package bbpw_pkg;

    // Field widths
    localparam int COORD_W  = 16;
    localparam int COLOR_W  = 16;
    localparam int BYTE_W   = 8;
    localparam int CLEN_W   = 12;
    localparam int WIDTH_W  = 10;
    localparam int BPR_W    = 11;
    localparam int BIR_W    = 11;
    localparam int MASK_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Limits applied to chunk length and bitmap width
    localparam int MAX_CHUNK_BYTES = 2048;
    localparam int MAX_WIDTH       = 1024;

    // Caps clipped to what the field widths can hold
    localparam int CHUNK_CAP_I = (MAX_CHUNK_BYTES < (1 << CLEN_W)) ?
                                 MAX_CHUNK_BYTES : ((1 << CLEN_W) - 1);
    localparam int WIDTH_CAP_I = (MAX_WIDTH < (1 << WIDTH_W)) ?
                                 MAX_WIDTH : ((1 << WIDTH_W) - 1);
    localparam logic [CLEN_W-1:0]  CHUNK_CAP = CLEN_W'(CHUNK_CAP_I);
    localparam logic [WIDTH_W-1:0] WIDTH_CAP = WIDTH_W'(WIDTH_CAP_I);

    // Command codes
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_BEGIN = 1'b1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_WIDTH     = 3'd2,
        REG_INK_COLOR = 3'd3,
        REG_MONO_MODE = 3'd4
    } cfg_reg_t;

endpackage

[rtl/bitmap_bytes_to_pixel_writes.sv]
// Top level: bitmap byte stream to pixel writes, 1bpp mono and RGB565 colour.
//
//  channel  | direction | handshake          | beat contents
//  ---------+-----------+--------------------+-------------------------------------------
//  s_       | in        | s_valid / s_ready  | opcode, data_byte, chunk_length, chunk_end
//  m_       | out       | m_valid / m_ready  | pixel_x, pixel_y, pixel_color, last_pixel
//  cfg_     | in        | cfg_wr_en          | cfg_addr, cfg_wdata
//
// A byte updates the row tracking in the cycle it is taken and parks its pixel mask in a
// work register; the emitter drains one pixel per cycle into the output register while it is free.
// A mono byte yields up to 8 pixels, a colour byte at most 1.
// The next byte is taken in the cycle the last pixel of the previous one leaves.
// Reset (aresetn low, synchronous) clears the config registers, tracking and both valids.
// A stalled m_ready holds the output register and, once the work register is busy, s_ready.
module bitmap_bytes_to_pixel_writes (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input beats
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_opcode,
    input  logic [bbpw_pkg::BYTE_W-1:0]        s_data_byte,
    input  logic [bbpw_pkg::CLEN_W-1:0]        s_chunk_length,
    input  logic                               s_chunk_end,
    // result beats
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [bbpw_pkg::COORD_W-1:0] m_pixel_x,
    output logic signed [bbpw_pkg::COORD_W-1:0] m_pixel_y,
    output logic [bbpw_pkg::COLOR_W-1:0]       m_pixel_color,
    output logic                               m_last_pixel,
    // configuration writes
    input  logic                               cfg_wr_en,
    input  logic [bbpw_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [bbpw_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import bbpw_pkg::*;

    // Configuration registers
    logic [COORD_W-1:0] origin_x_reg;
    logic [COORD_W-1:0] origin_y_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic [COLOR_W-1:0] ink_color_reg;
    logic               mono_mode_reg;

    // Row tracking
    logic               defined_reg, defined_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [CLEN_W-1:0]  row_start_reg, row_start_next;
    logic [BIR_W-1:0]   byte_in_row_reg, byte_in_row_next;
    logic [BYTE_W-1:0]  high_byte_reg, high_byte_next;

    // Work register: pixels still owed by the last accepted byte
    logic               wk_valid_reg;
    logic [MASK_W-1:0]  wk_mask_reg;
    logic [COORD_W-1:0] wk_x_reg;
    logic [COORD_W-1:0] wk_y_reg;
    logic [COLOR_W-1:0] wk_color_reg;

    // Output register
    logic               m_valid_reg;
    logic [COORD_W-1:0] m_x_reg;
    logic [COORD_W-1:0] m_y_reg;
    logic [COLOR_W-1:0] m_color_reg;
    logic               m_last_reg;

    // Step logic
    logic               in_fire;
    logic [CLEN_W-1:0]  clen_sat;
    logic [WIDTH_W-1:0] w_sat;
    logic [BPR_W-1:0]   bpr;
    logic               row_fits;
    logic               row_done;
    logic [MASK_W-1:0]  new_mask;
    logic [COORD_W-1:0] new_x;
    logic [COLOR_W-1:0] new_color;
    logic [WIDTH_W-1:0] pair_col;
    logic [13:0]        col_base;

    // Emitter
    logic               out_free;
    logic               emit_fire;
    logic [2:0]         pick;
    logic [MASK_W-1:0]  mask_rest;
    logic               emit_last;

    // Configuration write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            width_reg     <= '0;
            ink_color_reg <= '0;
            mono_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_ORIGIN_X:  origin_x_reg  <= cfg_wdata;
                REG_ORIGIN_Y:  origin_y_reg  <= cfg_wdata;
                REG_WIDTH:     width_reg     <= cfg_wdata[WIDTH_W-1:0];
                REG_INK_COLOR: ink_color_reg <= cfg_wdata;
                REG_MONO_MODE: mono_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Emitter: lowest set mask bit goes out first (MSB of the byte first)
    always_comb begin
        pick = 3'd0;
        for (int k = MASK_W - 1; k >= 0; k--) begin
            if (wk_mask_reg[k]) begin
                pick = 3'(k);
            end
        end
    end

    assign mask_rest = wk_mask_reg & (wk_mask_reg - MASK_W'(1));
    assign emit_last = (mask_rest == '0);
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_fire = wk_valid_reg && out_free;
    assign s_ready   = !wk_valid_reg || (emit_fire && emit_last);
    assign in_fire   = s_valid && s_ready;

    // Per-byte step: row fit, pixel mask and tracking update
    always_comb begin
        clen_sat = (s_chunk_length > CHUNK_CAP) ? CHUNK_CAP : s_chunk_length;
        w_sat    = (width_reg > WIDTH_CAP) ? WIDTH_CAP : width_reg;
        if (mono_mode_reg) begin
            bpr = BPR_W'((({1'b0, w_sat}) + 11'd7) >> 3);
        end else begin
            bpr = {w_sat, 1'b0};
        end
        row_fits = defined_reg && (bpr != '0) &&
                   ((13'(row_start_reg) + 13'(bpr)) <= 13'(clen_sat));
        row_done = (12'(byte_in_row_reg) + 12'd1) >= 12'(bpr);
        col_base = {byte_in_row_reg, 3'b000};
        pair_col = byte_in_row_reg[BIR_W-1:1];

        new_mask  = '0;
        new_x     = origin_x_reg;
        new_color = ink_color_reg;
        if (mono_mode_reg) begin
            new_x = origin_x_reg + COORD_W'(col_base);
            for (int k = 0; k < MASK_W; k++) begin
                new_mask[k] = s_data_byte[MASK_W-1-k] &&
                              ((col_base + 14'(k)) < 14'(w_sat));
            end
        end else begin
            new_x     = origin_x_reg + COORD_W'(pair_col);
            new_color = {high_byte_reg, s_data_byte};
            new_mask  = {7'b0, byte_in_row_reg[0] && (pair_col < w_sat)};
        end

        defined_next     = defined_reg;
        row_next         = row_reg;
        row_start_next   = row_start_reg;
        byte_in_row_next = byte_in_row_reg;
        high_byte_next   = high_byte_reg;
        if (s_opcode == OP_BEGIN) begin
            if (width_reg != '0) begin
                defined_next     = 1'b1;
                row_next         = origin_y_reg;
                row_start_next   = '0;
                byte_in_row_next = '0;
                high_byte_next   = '0;
            end
        end else begin
            if (row_fits) begin
                if (!mono_mode_reg && !byte_in_row_reg[0]) begin
                    high_byte_next = s_data_byte;
                end
                if (row_done) begin
                    row_next         = row_reg + COORD_W'(1);
                    row_start_next   = row_start_reg + CLEN_W'(bpr);
                    byte_in_row_next = '0;
                end else begin
                    byte_in_row_next = byte_in_row_reg + BIR_W'(1);
                end
            end
            // drop any partial row at chunk end
            if (s_chunk_end) begin
                row_start_next   = '0;
                byte_in_row_next = '0;
            end
        end
        if (s_opcode == OP_BEGIN || !row_fits) begin
            new_mask = '0;
        end
    end

    // Tracking state, work register and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            defined_reg     <= 1'b0;
            row_reg         <= '0;
            row_start_reg   <= '0;
            byte_in_row_reg <= '0;
            high_byte_reg   <= '0;
            wk_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (in_fire) begin
                defined_reg     <= defined_next;
                row_reg         <= row_next;
                row_start_reg   <= row_start_next;
                byte_in_row_reg <= byte_in_row_next;
                high_byte_reg   <= high_byte_next;
            end

            // advance the work register: drop the sent pixel, load a new byte
            if (in_fire) begin
                wk_valid_reg <= (new_mask != '0);
                wk_mask_reg  <= new_mask;
                wk_x_reg     <= new_x;
                wk_y_reg     <= row_reg;
                wk_color_reg <= new_color;
            end else if (emit_fire) begin
                wk_mask_reg  <= mask_rest;
                wk_valid_reg <= !emit_last;
            end

            // hold the output beat until taken
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
                m_x_reg     <= wk_x_reg + COORD_W'(pick);
                m_y_reg     <= wk_y_reg;
                m_color_reg <= wk_color_reg;
                m_last_reg  <= emit_last;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = signed'(m_x_reg);
    assign m_pixel_y     = signed'(m_y_reg);
    assign m_pixel_color = m_color_reg;
    assign m_last_pixel  = m_last_reg;

`ifndef NO_ASSERTIONS
    // a busy work register always owes at least one pixel
    assert property (@(posedge aclk) disable iff (!aresetn)
        wk_valid_reg |-> (wk_mask_reg != '0))
        else $error("work register valid with empty pixel mask");

    // a new byte never overwrites pixels still owed
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |-> (!wk_valid_reg || (emit_fire && emit_last)))
        else $error("byte accepted over pending pixels");

    // every emitted pixel lands in the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire |=> m_valid_reg)
        else $error("emitted pixel missing from output register");

    // reset empties both stages
    assert property (@(posedge aclk)
        !aresetn |=> (!m_valid_reg && !wk_valid_reg))
        else $error("valid state survived reset");
`endif

endmodule
